// ===== rtl/core/csmv_pkg.sv =====
// ----------------------------------------------------------------------------
// csmv_pkg
// Shared types, codes and arithmetic helpers for the sparse matrix-vector
// accumulate core.
// ----------------------------------------------------------------------------
package csmv_pkg;

    localparam int DEF_MAX_ROWS = 4096;
    localparam int DEF_MAX_COLS = 4096;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_GAIN = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BETA_GAIN  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT  = 8'd3;

    localparam logic signed [VALUE_W-1:0] ALPHA_RESET = 32'sd65536;
    localparam logic signed [VALUE_W-1:0] BETA_RESET  = 32'sd0;
    localparam logic [COUNT_W-1:0]        COUNT_RESET = 13'd4096;

    localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        MODE_LOAD_X  = 2'd0,
        MODE_LOAD_Y  = 2'd1,
        MODE_NONZERO = 2'd2,
        MODE_READ_Y  = 2'd3
    } csmv_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCALE,
        ST_UPDATE,
        ST_RESULT
    } csmv_state_t;

    typedef struct packed {
        csmv_mode_t                 mode;
        logic [INDEX_W-1:0]         row_index;
        logic [INDEX_W-1:0]         col_index;
        logic signed [VALUE_W-1:0]  value;
    } csmv_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        logic                       status;
    } csmv_result_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  alpha_gain;
        logic signed [VALUE_W-1:0]  beta_gain;
        logic [COUNT_W-1:0]         row_count;
        logic [COUNT_W-1:0]         col_count;
    } csmv_cfg_t;

    // Drops the low 16 fraction bits (floor) and saturates to 32 bits.
    function automatic logic signed [VALUE_W-1:0] qsat(input logic signed [63:0] p);
        logic signed [VALUE_W-1:0] r;
        if ((p[63:47] == '0) || (p[63:47] == '1))
        begin
            r = p[47:16];
        end
        else if (p[63])
        begin
            r = Q_MIN;
        end
        else
        begin
            r = Q_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_add(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic [VALUE_W:0]          s;
        logic signed [VALUE_W-1:0] r;
        s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        if (s[VALUE_W] == s[VALUE_W-1])
        begin
            r = s[VALUE_W-1:0];
        end
        else if (s[VALUE_W])
        begin
            r = Q_MIN;
        end
        else
        begin
            r = Q_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/csmv_store.sv =====
// ----------------------------------------------------------------------------
// csmv_store
// Single-port-write, single-port-read synchronous memory with registered
// read data, used for the x and y vectors.
// ----------------------------------------------------------------------------
module csmv_store import csmv_pkg::*; #(
    parameter int DEPTH = DEF_MAX_ROWS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic signed [VALUE_W-1:0]  wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [VALUE_W-1:0]  rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/csmv_ctrl.sv =====
// ----------------------------------------------------------------------------
// csmv_ctrl
// Request sequencer and datapath: range checks, the shared Q16.16
// multiplier, read-modify-write of the y store and the result register.
// ----------------------------------------------------------------------------
module csmv_ctrl import csmv_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  csmv_item_t                 item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output csmv_result_t               result,
    input  csmv_cfg_t                  cfg,
    output logic                       x_wr_en,
    output logic [COL_AW-1:0]          x_wr_addr,
    output logic signed [VALUE_W-1:0]  x_wr_data,
    output logic                       x_rd_en,
    output logic [COL_AW-1:0]          x_rd_addr,
    input  logic signed [VALUE_W-1:0]  x_rd_data,
    output logic                       y_wr_en,
    output logic [ROW_AW-1:0]          y_wr_addr,
    output logic signed [VALUE_W-1:0]  y_wr_data,
    output logic                       y_rd_en,
    output logic [ROW_AW-1:0]          y_rd_addr,
    input  logic signed [VALUE_W-1:0]  y_rd_data
);

    localparam logic [16:0] ROW_LIMIT = 17'(MAX_ROWS);
    localparam logic [16:0] COL_LIMIT = 17'(MAX_COLS);

    csmv_state_t               state_reg, state_next;
    csmv_item_t                item_reg;
    logic                      ok_reg, ok_next;
    logic signed [VALUE_W-1:0] term_reg, term_next;
    logic signed [VALUE_W-1:0] rdval_reg, rdval_next;
    logic                      out_valid_reg, out_valid_next;
    csmv_result_t              out_data_reg, out_data_next;

    logic                      accept;
    logic                      row_ok;
    logic                      col_ok;
    logic                      out_free;
    logic signed [VALUE_W-1:0] mul_a;
    logic signed [VALUE_W-1:0] mul_b;
    logic signed [63:0]        product;

    assign accept   = item_valid && !item_stall;
    assign out_free = !out_valid_reg || !result_stall;

    assign row_ok = ({1'b0, item.row_index} < cfg.row_count)
                 && ({5'b0, item.row_index} < ROW_LIMIT);
    assign col_ok = ({1'b0, item.col_index} < cfg.col_count)
                 && ({5'b0, item.col_index} < COL_LIMIT);

    always_comb
    begin
        case (item.mode)
            MODE_LOAD_X:  ok_next = col_ok;
            MODE_NONZERO: ok_next = row_ok && col_ok;
            default:      ok_next = row_ok;
        endcase
    end

    assign mul_a   = (state_reg == ST_SCALE) ? term_reg :
                     ((item_reg.mode == MODE_LOAD_Y) ? cfg.beta_gain : cfg.alpha_gain);
    assign mul_b   = (state_reg == ST_SCALE) ? x_rd_data : item_reg.value;
    assign product = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!ok_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    case (item_reg.mode)
                        MODE_LOAD_Y:  state_next = ST_UPDATE;
                        MODE_NONZERO: state_next = ST_SCALE;
                        default:      state_next = ST_RESULT;
                    endcase
                end
            end
            ST_SCALE:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall     = (state_reg != ST_IDLE);
        x_rd_en        = accept;
        y_rd_en        = accept;
        x_wr_en        = 1'b0;
        y_wr_en        = 1'b0;
        y_wr_data      = (item_reg.mode == MODE_LOAD_Y) ? term_reg
                                                        : sat_add(y_rd_data, term_reg);
        term_next      = term_reg;
        rdval_next     = rdval_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_EXEC:
            begin
                term_next  = qsat(product);
                rdval_next = (ok_reg && (item_reg.mode == MODE_READ_Y)) ? y_rd_data : '0;
                x_wr_en    = ok_reg && (item_reg.mode == MODE_LOAD_X);
            end
            ST_SCALE:
            begin
                term_next = qsat(product);
            end
            ST_UPDATE:
            begin
                y_wr_en = 1'b1;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.read_value = rdval_reg;
                    out_data_next.status     = !ok_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign x_rd_addr = COL_AW'(item.col_index);
    assign y_rd_addr = ROW_AW'(item.row_index);
    assign x_wr_addr = COL_AW'(item_reg.col_index);
    assign y_wr_addr = ROW_AW'(item_reg.row_index);
    assign x_wr_data = item_reg.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            ok_reg   <= ok_next;
        end
        term_reg     <= term_next;
        rdval_reg    <= rdval_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ===== rtl/core/coo_sparse_matvec_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// coo_sparse_matvec_accumulate_core
// Sparse matrix-vector multiply-accumulate y = alpha*A*x + beta*y over
// coordinate triples, with x and y held in on-chip memories.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Content
// item      in         item_valid/item_stall      mode, row_index, col_index, value
// result    out        result_valid/result_stall  read_value, status
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One request is handled at a time. A load of x, a read of y or a request with
// an index out of range steps through EXEC and RESULT; a load of y adds UPDATE,
// a nonzero adds SCALE and UPDATE: single shared multiplier, read-modify-write of y.
// The next request is taken while the previous result waits in the output register.
// Reset restores the configuration registers; the x and y memories are not cleared.
// ----------------------------------------------------------------------------
module coo_sparse_matvec_accumulate_core import csmv_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  csmv_item_t               item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output csmv_result_t             result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [VALUE_W-1:0]       cfg_data
);

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    csmv_cfg_t                 cfg_reg;
    logic                      x_wr_en, x_rd_en, y_wr_en, y_rd_en;
    logic [COL_AW-1:0]         x_wr_addr, x_rd_addr;
    logic [ROW_AW-1:0]         y_wr_addr, y_rd_addr;
    logic signed [VALUE_W-1:0] x_wr_data, x_rd_data, y_wr_data, y_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_gain <= ALPHA_RESET;
            cfg_reg.beta_gain  <= BETA_RESET;
            cfg_reg.row_count  <= COUNT_RESET;
            cfg_reg.col_count  <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ALPHA_GAIN: cfg_reg.alpha_gain <= cfg_data;
                CFG_BETA_GAIN:  cfg_reg.beta_gain  <= cfg_data;
                CFG_ROW_COUNT:  cfg_reg.row_count  <= cfg_data[COUNT_W-1:0];
                CFG_COL_COUNT:  cfg_reg.col_count  <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    csmv_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ROW_AW   (ROW_AW),
        .COL_AW   (COL_AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg          (cfg_reg),
        .x_wr_en      (x_wr_en),
        .x_wr_addr    (x_wr_addr),
        .x_wr_data    (x_wr_data),
        .x_rd_en      (x_rd_en),
        .x_rd_addr    (x_rd_addr),
        .x_rd_data    (x_rd_data),
        .y_wr_en      (y_wr_en),
        .y_wr_addr    (y_wr_addr),
        .y_wr_data    (y_wr_data),
        .y_rd_en      (y_rd_en),
        .y_rd_addr    (y_rd_addr),
        .y_rd_data    (y_rd_data)
    );

    csmv_store #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (COL_AW)
    ) u_x_store (
        .clk     (clk),
        .wr_en   (x_wr_en),
        .wr_addr (x_wr_addr),
        .wr_data (x_wr_data),
        .rd_en   (x_rd_en),
        .rd_addr (x_rd_addr),
        .rd_data (x_rd_data)
    );

    csmv_store #(
        .DEPTH  (MAX_ROWS),
        .ADDR_W (ROW_AW)
    ) u_y_store (
        .clk     (clk),
        .wr_en   (y_wr_en),
        .wr_addr (y_wr_addr),
        .wr_data (y_wr_data),
        .rd_en   (y_rd_en),
        .rd_addr (y_rd_addr),
        .rd_data (y_rd_data)
    );

endmodule

// ===== sim/coo_sparse_matvec_accumulate_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coo_sparse_matvec_accumulate_core_tb
// Self-checking bench for the sparse matrix-vector accumulate core. A short
// table of requests covers the value and index extremes, saturation, rounding
// and out-of-range indices. Random phases under several gain and size settings
// follow. Table results are checked against the table, the others against a
// fixed-point predictor of x and y, with random idle gaps and result stalls.
// ----------------------------------------------------------------------------
module coo_sparse_matvec_accumulate_core_tb;

    import csmv_pkg::*;

    localparam bit BY_TABLE     = 1'b1;
    localparam bit BY_PREDICTOR = 1'b0;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 250;

    typedef struct {
        bit                        is_cfg;
        logic [CFG_INDEX_W-1:0]    cfg_sel;
        logic [VALUE_W-1:0]        cfg_word;
        csmv_item_t                req;
        bit                        typed;
        csmv_result_t              want;
    } plan_step_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_stall;
    csmv_item_t              item = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    csmv_result_t            result;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [VALUE_W-1:0]      cfg_data = '0;

    logic signed [VALUE_W-1:0] xvec [0:DEF_MAX_COLS-1];
    logic signed [VALUE_W-1:0] yvec [0:DEF_MAX_ROWS-1];
    bit                        xvec_set [0:DEF_MAX_COLS-1];
    bit                        yvec_set [0:DEF_MAX_ROWS-1];
    logic signed [VALUE_W-1:0] alpha_q = ALPHA_RESET;
    logic signed [VALUE_W-1:0] beta_q = BETA_RESET;
    int                        row_span = DEF_MAX_ROWS;
    int                        col_span = DEF_MAX_COLS;
    int                        last_nz_row = 0;

    csmv_result_t owed_results[$];
    int           mismatches = 0;
    bit           idle_on = 1'b1;
    bit           hold_req = 1'b0;

    coo_sparse_matvec_accumulate_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [VALUE_W-1:0] q_clip(input longint v);
        if (v > longint'(Q_MAX))
        begin
            return Q_MAX;
        end
        if (v < longint'(Q_MIN))
        begin
            return Q_MIN;
        end
        return v[VALUE_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] q_mul(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        longint p;
        p = longint'(a) * longint'(b);
        p = p >>> 16;
        return q_clip(p);
    endfunction

    function automatic csmv_result_t spmv_step(input csmv_item_t it);
        csmv_result_t              res;
        logic signed [VALUE_W-1:0] term;
        bit                        row_ok;
        bit                        col_ok;
        res = '0;
        row_ok = int'(it.row_index) < row_span;
        col_ok = int'(it.col_index) < col_span;
        case (it.mode)
            MODE_LOAD_X:
            begin
                if (col_ok)
                begin
                    xvec[it.col_index] = it.value;
                    xvec_set[it.col_index] = 1'b1;
                end
                else
                begin
                    res.status = 1'b1;
                end
            end
            MODE_LOAD_Y:
            begin
                if (row_ok)
                begin
                    yvec[it.row_index] = q_mul(beta_q, it.value);
                    yvec_set[it.row_index] = 1'b1;
                end
                else
                begin
                    res.status = 1'b1;
                end
            end
            MODE_NONZERO:
            begin
                if (row_ok && col_ok)
                begin
                    term = q_mul(q_mul(alpha_q, it.value), xvec[it.col_index]);
                    yvec[it.row_index] = q_clip(longint'(yvec[it.row_index]) + longint'(term));
                end
                else
                begin
                    res.status = 1'b1;
                end
            end
            default:
            begin
                if (row_ok)
                begin
                    res.read_value = yvec[it.row_index];
                end
                else
                begin
                    res.status = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    function automatic int load_index(input int lim);
        int hot;
        int k;
        hot = (lim < 32) ? lim : 32;
        k = $urandom_range(0, 9);
        if (k < 6)
        begin
            return $urandom_range(0, hot - 1);
        end
        if (k < 9)
        begin
            return $urandom_range(0, lim - 1);
        end
        return $urandom_range(0, DEF_MAX_ROWS - 1);
    endfunction

    function automatic int pick_written(input bit is_row, input int lim);
        int hot;
        int k;
        int idx;
        hot = (lim < 32) ? lim : 32;
        for (k = 0; k < 24; k++)
        begin
            idx = (k < 16) ? $urandom_range(0, hot - 1) : $urandom_range(0, lim - 1);
            if (is_row ? yvec_set[idx] : xvec_set[idx])
            begin
                return idx;
            end
        end
        return -1;
    endfunction

    // Nonzeros and reads only touch rows and columns that hold data.
    function automatic csmv_item_t next_request();
        csmv_item_t it;
        int         roll;
        int         r;
        int         c;
        bit         row_ok;
        bit         col_ok;
        roll = $urandom_range(0, 99);
        it.mode = MODE_LOAD_Y;
        it.row_index = INDEX_W'($urandom_range(0, DEF_MAX_ROWS - 1));
        it.col_index = INDEX_W'($urandom_range(0, DEF_MAX_COLS - 1));
        case ($urandom_range(0, 9))
            0: it.value = Q_MAX;
            1: it.value = Q_MIN;
            2: it.value = ($urandom_range(0, 1) == 0) ? 32'sh0001_0000 : -32'sh0001_0000;
            3: it.value = ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
            4: it.value = $signed($urandom) >>> 16;
            default: it.value = $signed($urandom) >>> $urandom_range(4, 14);
        endcase
        r = pick_written(1'b1, row_span);
        c = pick_written(1'b0, col_span);
        if (roll < 16)
        begin
            it.mode = MODE_LOAD_X;
            it.col_index = INDEX_W'(load_index(col_span));
        end
        else if (roll < 32)
        begin
            it.mode = MODE_LOAD_Y;
            it.row_index = INDEX_W'(load_index(row_span));
        end
        else if (roll < 80 && r >= 0 && c >= 0)
        begin
            it.mode = MODE_NONZERO;
            it.row_index = INDEX_W'(($urandom_range(0, 2) == 0) ? last_nz_row : r);
            it.col_index = INDEX_W'(c);
            last_nz_row = int'(it.row_index);
        end
        else if (roll < 95 && r >= 0)
        begin
            it.mode = MODE_READ_Y;
            it.row_index = INDEX_W'(r);
        end
        else
        begin
            it.mode = csmv_mode_t'($urandom_range(0, 3));
        end
        row_ok = int'(it.row_index) < row_span;
        col_ok = int'(it.col_index) < col_span;
        if ((it.mode == MODE_NONZERO && row_ok && col_ok
                && !(xvec_set[it.col_index] && yvec_set[it.row_index]))
            || (it.mode == MODE_READ_Y && row_ok && !yvec_set[it.row_index]))
        begin
            it.mode = MODE_LOAD_Y;
        end
        return it;
    endfunction

    function automatic plan_step_t req_step(
        input csmv_mode_t         m,
        input int                 r,
        input int                 c,
        input logic [VALUE_W-1:0] v,
        input bit                 typed,
        input logic [VALUE_W-1:0] rv,
        input logic               st
    );
        plan_step_t s;
        s.is_cfg = 1'b0;
        s.cfg_sel = '0;
        s.cfg_word = '0;
        s.req.mode = m;
        s.req.row_index = INDEX_W'(r);
        s.req.col_index = INDEX_W'(c);
        s.req.value = v;
        s.typed = typed;
        s.want.read_value = rv;
        s.want.status = st;
        return s;
    endfunction

    function automatic plan_step_t cfg_step(
        input logic [CFG_INDEX_W-1:0] sel,
        input logic [VALUE_W-1:0]     data
    );
        plan_step_t s;
        s = req_step(MODE_LOAD_X, 0, 0, '0, BY_PREDICTOR, '0, 1'b0);
        s.is_cfg = 1'b1;
        s.cfg_sel = sel;
        s.cfg_word = data;
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic drain_results();
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    task automatic send_request(
        input csmv_item_t   it,
        input bit           typed,
        input csmv_result_t want
    );
        csmv_result_t forecast;
        int           gap;
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        forecast = spmv_step(it);
        owed_results.push_back(typed ? want : forecast);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_register(
        input logic [CFG_INDEX_W-1:0] sel,
        input logic [VALUE_W-1:0]     data
    );
        int count;
        item_valid <= 1'b0;
        drain_results();
        cfg_index <= sel;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        count = int'(data[COUNT_W-1:0]);
        case (sel)
            CFG_ALPHA_GAIN: alpha_q = data;
            CFG_BETA_GAIN:  beta_q = data;
            CFG_ROW_COUNT:  row_span = (count < DEF_MAX_ROWS) ? count : DEF_MAX_ROWS;
            CFG_COL_COUNT:  col_span = (count < DEF_MAX_COLS) ? count : DEF_MAX_COLS;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin : result_check
        csmv_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no request pending", result));
            end
            else
            begin
                want = owed_results.pop_front();
                if (result.read_value !== want.read_value)
                begin
                    report_mismatch($sformatf("read_value %h, predicted %h",
                                              result.read_value, want.read_value));
                end
                if (result.status !== want.status)
                begin
                    report_mismatch($sformatf("status %b, predicted %b",
                                              result.status, want.status));
                end
            end
        end
    end

    initial
    begin
        int span;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (400) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
                result_stall <= 1'b1;
                repeat (span) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        plan_step_t                plan[$];
        int                        phase;
        int                        n;
        logic signed [VALUE_W-1:0] a_word;
        logic signed [VALUE_W-1:0] b_word;
        int                        r_word;
        int                        c_word;

        plan.push_back(req_step(MODE_LOAD_X, 0, 0, 32'h0002_0000, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_LOAD_X, 0, 4095, Q_MAX, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_LOAD_X, 0, 7, Q_MIN, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_LOAD_Y, 0, 0, 32'h0000_3039, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_LOAD_Y, 4095, 0, Q_MAX, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_NONZERO, 0, 0, 32'h0001_0000, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_READ_Y, 0, 0, '0, BY_TABLE, 32'h0002_0000, 1'b0));
        plan.push_back(req_step(MODE_NONZERO, 4095, 4095, Q_MAX, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_READ_Y, 4095, 0, '0, BY_TABLE, Q_MAX, 1'b0));
        plan.push_back(req_step(MODE_NONZERO, 0, 7, Q_MAX, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_NONZERO, 0, 7, Q_MAX, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_READ_Y, 0, 0, '0, BY_TABLE, Q_MIN, 1'b0));
        plan.push_back(req_step(MODE_LOAD_X, 0, 1, 32'hFFFF_FFFF, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_LOAD_Y, 1, 0, 32'h0000_0005, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_NONZERO, 1, 1, 32'h0000_0001, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_READ_Y, 1, 0, '0, BY_TABLE, 32'hFFFF_FFFF, 1'b0));
        plan.push_back(cfg_step(CFG_ROW_COUNT, 32'd1));
        plan.push_back(cfg_step(CFG_COL_COUNT, 32'd1));
        plan.push_back(req_step(MODE_LOAD_X, 0, 1, 32'h0000_0009, BY_TABLE, '0, 1'b1));
        plan.push_back(req_step(MODE_LOAD_Y, 1, 0, 32'h0000_0009, BY_TABLE, '0, 1'b1));
        plan.push_back(req_step(MODE_NONZERO, 0, 1, 32'h0001_0000, BY_TABLE, '0, 1'b1));
        plan.push_back(req_step(MODE_NONZERO, 1, 0, 32'h0001_0000, BY_TABLE, '0, 1'b1));
        plan.push_back(req_step(MODE_LOAD_X, 4095, 0, 32'h0003_0000, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_READ_Y, 0, 4095, '0, BY_TABLE, Q_MIN, 1'b0));
        plan.push_back(cfg_step(CFG_BETA_GAIN, 32'hFFFF_0000));
        plan.push_back(req_step(MODE_LOAD_Y, 0, 0, Q_MIN, BY_TABLE, '0, 1'b0));
        plan.push_back(req_step(MODE_READ_Y, 0, 0, '0, BY_TABLE, Q_MAX, 1'b0));
        plan.push_back(cfg_step(CFG_ALPHA_GAIN, 32'h0000_8000));
        plan.push_back(req_step(MODE_NONZERO, 0, 0, 32'hFFF8_0000, BY_PREDICTOR, '0, 1'b0));
        plan.push_back(req_step(MODE_READ_Y, 0, 0, '0, BY_PREDICTOR, '0, 1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                set_register(plan[i].cfg_sel, plan[i].cfg_word);
            end
            else
            begin
                send_request(plan[i].req, plan[i].typed, plan[i].want);
            end
        end

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    a_word = 32'sh0001_0000;
                    b_word = 32'sh0001_0000;
                    r_word = DEF_MAX_ROWS;
                    c_word = DEF_MAX_COLS;
                end
                1:
                begin
                    a_word = Q_MAX;
                    b_word = Q_MIN;
                    r_word = DEF_MAX_ROWS;
                    c_word = DEF_MAX_COLS;
                end
                2:
                begin
                    a_word = Q_MIN;
                    b_word = Q_MAX;
                    r_word = 1;
                    c_word = 1;
                end
                3:
                begin
                    a_word = 32'sh0000_8000;
                    b_word = -32'sh0001_0000;
                    r_word = 16;
                    c_word = DEF_MAX_COLS;
                end
                default:
                begin
                    a_word = $signed($urandom) >>> $urandom_range(12, 18);
                    b_word = $signed($urandom) >>> $urandom_range(12, 18);
                    r_word = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                         : $urandom_range(1, DEF_MAX_ROWS);
                    c_word = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                         : $urandom_range(1, DEF_MAX_COLS);
                end
            endcase
            set_register(CFG_ALPHA_GAIN, a_word);
            set_register(CFG_BETA_GAIN, b_word);
            set_register(CFG_ROW_COUNT, r_word);
            set_register(CFG_COL_COUNT, c_word);
            idle_on = (phase % 3) != 2;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // The result side holds off while requests keep coming, so the
                // core fills up and pushes back on its input.
                if (phase == 1 && n == 40)
                begin
                    idle_on = 1'b0;
                    hold_req = 1'b1;
                end
                if (phase == 1 && n == 140)
                begin
                    idle_on = 1'b1;
                end
                if (phase == 4 && n == 125)
                begin
                    item_valid <= 1'b0;
                    drain_results();
                end
                send_request(next_request(), BY_PREDICTOR, '0);
            end
        end

        item_valid <= 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
